// ----- design/bbd_pkg.sv -----
// Shared constants, types and helper functions of the binarizing box downsampler.
package bbd_pkg;

    localparam int GRID    = 28;
    localparam int MAX_DIM = 4096;

    // Fixed widths of the port fields
    localparam int PIX_W     = 8;
    localparam int CFG_DIM_W = 13;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_IDX_W = 5;
    localparam int DARK_W    = 9;
    localparam int FRAC_BITS = 8;

    // Derived internal widths
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int REM_W    = $clog2(GRID);
    localparam int GX_W     = $clog2(GRID);
    localparam int CELL_MAX = (MAX_DIM + GRID - 1) / GRID;
    localparam int CELL_W   = $clog2(CELL_MAX + 1);
    localparam int COUNT_W  = $clog2(CELL_MAX * CELL_MAX + 1);
    localparam int SUM_W    = PIX_W + 2;

    // A pixel is dark when floor(sum / 3) < 128, that is sum < 384
    localparam logic [SUM_W-1:0] DARK_SUM = SUM_W'(3 * 128);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE   = CFG_IDX_W'(2);

    // Color modes at or above this code count every pixel as light
    localparam logic [MODE_W-1:0] MODE_UNSUPPORTED = MODE_W'(2);

    localparam logic [CFG_DIM_W-1:0] RESET_DIM  = CFG_DIM_W'(28);
    localparam logic [MODE_W-1:0]    RESET_MODE = MODE_W'(0);

    // Reciprocal of GRID for the width and height split
    localparam int RECIP_SHIFT = DIM_W + 6;
    localparam int PROD_W      = DIM_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'((64'(1) << RECIP_SHIFT) / GRID);

    // Cycles from a register write until the derived sizes are usable
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Cell boundary: pixel index plus the running remainder of i*n mod GRID
    typedef struct packed {
        logic [DIM_W-1:0] pos;
        logic [REM_W-1:0] rem;
    } mark_t;

    // Frame geometry handed from the register block to the datapath
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] wq;
        logic [REM_W-1:0] wr;
        logic [DIM_W-1:0] hq;
        logic [REM_W-1:0] hr;
        logic             dark_ok;
        logic             busy;
        logic             init;
    } dims_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] raw);
        logic [31:0] v;
        v = 32'(raw);
        if (v < 32'(GRID)) begin
            v = 32'(GRID);
        end else if (v > 32'(MAX_DIM)) begin
            v = 32'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    // floor(n / GRID) or one less; corrected by one compare afterwards
    function automatic logic [DIM_W-1:0] quot_estimate(input logic [DIM_W-1:0] n);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(n) * PROD_W'(RECIP);
        return DIM_W'(prod >> RECIP_SHIFT);
    endfunction

    // Advance a boundary from cell i to cell i+1: adds n/GRID with carry
    function automatic mark_t mark_step(input mark_t m,
                                        input logic [DIM_W-1:0] q0,
                                        input logic [REM_W-1:0] r0);
        logic [REM_W:0] s;
        mark_t o;
        s = {1'b0, m.rem} + {1'b0, r0};
        if (s >= (REM_W+1)'(GRID)) begin
            o.pos = m.pos + q0 + DIM_W'(1);
            o.rem = REM_W'(s - (REM_W+1)'(GRID));
        end else begin
            o.pos = m.pos + q0;
            o.rem = REM_W'(s);
        end
        return o;
    endfunction

endpackage

// ----- design/bbd_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/bbd_cfg.sv -----
// Configuration registers and derived frame geometry.
module bbd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data,
    output bbd_pkg::dims_t                 dims
);

    logic [bbd_pkg::CFG_DIM_W-1:0] width_raw_reg;
    logic [bbd_pkg::CFG_DIM_W-1:0] height_raw_reg;
    logic [bbd_pkg::MODE_W-1:0]    mode_reg;
    logic [1:0]                    settle_reg;
    logic                          restart;

    logic [bbd_pkg::DIM_W-1:0] w_clamp_reg;
    logic [bbd_pkg::DIM_W-1:0] h_clamp_reg;
    logic [bbd_pkg::DIM_W-1:0] wq_est_reg;
    logic [bbd_pkg::DIM_W-1:0] hq_est_reg;
    logic                      dark_ok_reg;

    logic [bbd_pkg::DIM_W-1:0] width_reg;
    logic [bbd_pkg::DIM_W-1:0] height_reg;
    logic [bbd_pkg::DIM_W-1:0] wq_reg;
    logic [bbd_pkg::REM_W-1:0] wr_reg;
    logic [bbd_pkg::DIM_W-1:0] hq_reg;
    logic [bbd_pkg::REM_W-1:0] hr_reg;
    logic                      dark_ok_out_reg;

    logic [bbd_pkg::DIM_W-1:0] w_rem;
    logic [bbd_pkg::DIM_W-1:0] h_rem;

    assign cfg_ready = 1'b1;

    always_comb begin
        restart = 1'b0;
        if (cfg_valid) begin
            case (cfg_index)
                bbd_pkg::REG_IMAGE_WIDTH:  restart = 1'b1;
                bbd_pkg::REG_IMAGE_HEIGHT: restart = 1'b1;
                bbd_pkg::REG_COLOR_MODE:   restart = 1'b1;
                default:                   restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_raw_reg  <= bbd_pkg::RESET_DIM;
            height_raw_reg <= bbd_pkg::RESET_DIM;
            mode_reg       <= bbd_pkg::RESET_MODE;
            settle_reg     <= bbd_pkg::SETTLE_CYCLES;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    bbd_pkg::REG_IMAGE_WIDTH:  width_raw_reg  <= cfg_data;
                    bbd_pkg::REG_IMAGE_HEIGHT: height_raw_reg <= cfg_data;
                    bbd_pkg::REG_COLOR_MODE:   mode_reg <= cfg_data[bbd_pkg::MODE_W-1:0];
                    default: ;
                endcase
            end
            if (restart) begin
                settle_reg <= bbd_pkg::SETTLE_CYCLES;
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // Remainder of the estimate; one compare fixes a quotient that is one short
    assign w_rem = w_clamp_reg - bbd_pkg::DIM_W'(32'(wq_est_reg) * bbd_pkg::GRID);
    assign h_rem = h_clamp_reg - bbd_pkg::DIM_W'(32'(hq_est_reg) * bbd_pkg::GRID);

    always_ff @(posedge aclk) begin
        w_clamp_reg <= bbd_pkg::clamp_dim(width_raw_reg);
        h_clamp_reg <= bbd_pkg::clamp_dim(height_raw_reg);
        wq_est_reg  <= bbd_pkg::quot_estimate(bbd_pkg::clamp_dim(width_raw_reg));
        hq_est_reg  <= bbd_pkg::quot_estimate(bbd_pkg::clamp_dim(height_raw_reg));
        dark_ok_reg <= (mode_reg < bbd_pkg::MODE_UNSUPPORTED);

        width_reg       <= w_clamp_reg;
        height_reg      <= h_clamp_reg;
        dark_ok_out_reg <= dark_ok_reg;
        if (w_rem >= bbd_pkg::DIM_W'(bbd_pkg::GRID)) begin
            wq_reg <= wq_est_reg + bbd_pkg::DIM_W'(1);
            wr_reg <= bbd_pkg::REM_W'(w_rem - bbd_pkg::DIM_W'(bbd_pkg::GRID));
        end else begin
            wq_reg <= wq_est_reg;
            wr_reg <= bbd_pkg::REM_W'(w_rem);
        end
        if (h_rem >= bbd_pkg::DIM_W'(bbd_pkg::GRID)) begin
            hq_reg <= hq_est_reg + bbd_pkg::DIM_W'(1);
            hr_reg <= bbd_pkg::REM_W'(h_rem - bbd_pkg::DIM_W'(bbd_pkg::GRID));
        end else begin
            hq_reg <= hq_est_reg;
            hr_reg <= bbd_pkg::REM_W'(h_rem);
        end
    end

    always_comb begin
        dims.width   = width_reg;
        dims.height  = height_reg;
        dims.wq      = wq_reg;
        dims.wr      = wr_reg;
        dims.hq      = hq_reg;
        dims.hr      = hr_reg;
        dims.dark_ok = dark_ok_out_reg;
        dims.busy    = (settle_reg != 2'd0);
        dims.init    = (settle_reg == 2'd1);
    end

endmodule

// ----- design/bbd_div.sv -----
// Radix-2 divider for the Q1.8 darkness fraction, one quotient bit per cycle.
module bbd_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bbd_pkg::COUNT_W-1:0]  dividend,
    input  logic [bbd_pkg::COUNT_W-1:0]  divisor,
    output logic                         done,
    output logic [bbd_pkg::DARK_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(bbd_pkg::FRAC_BITS + 1);

    logic [bbd_pkg::COUNT_W-1:0] rem_reg;
    logic [bbd_pkg::COUNT_W-1:0] divisor_reg;
    logic [bbd_pkg::DARK_W-1:0]  quot_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [bbd_pkg::COUNT_W:0] rem2;
    logic                      bit_ge;

    assign rem2   = {rem_reg, 1'b0};
    assign bit_ge = rem2 >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // Integer bit: the count equals the cell size only when all dark
            divisor_reg <= divisor;
            step_reg    <= STEP_W'(bbd_pkg::FRAC_BITS);
            if (dividend >= divisor) begin
                rem_reg  <= dividend - divisor;
                quot_reg <= bbd_pkg::DARK_W'(1);
            end else begin
                rem_reg  <= dividend;
                quot_reg <= '0;
            end
        end else if (busy_reg) begin
            step_reg <= step_reg - STEP_W'(1);
            quot_reg <= {quot_reg[bbd_pkg::DARK_W-2:0], bit_ge};
            if (bit_ge) begin
                rem_reg <= bbd_pkg::COUNT_W'(rem2 - {1'b0, divisor_reg});
            end else begin
                rem_reg <= bbd_pkg::COUNT_W'(rem2);
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- design/binarize_box_downsample.sv -----
// Top level of the binarizing box downsampler.
// Pixels enter on the s_ channel (s_red, s_green, s_blue) in raster order,
// one per accepted item. Each pixel is dark when the mean of its channels is
// below 128; dark pixels are counted per grid cell in a 28-entry count memory.
// Each pixel's cell count is read when it is accepted and written back in
// ST_UPDATE. After the last pixel row of a band, the block emits 28 items on
// the m_ channel, left to right: cell_column, cell_row, darkness (Q1.8) and
// the band_last / image_last flags. Each cell goes through a count read, an
// 8x8 multiply for the cell size and a 9-step divider; the input is held
// (s_ready low) while a band's cells are emitted. The result register lets
// the last cell of a band wait on m_ready while new pixels are taken; a
// stalled receiver otherwise holds the band sequence. The cfg_ port writes
// image_width (0), image_height (1) and color_mode (2); cfg_ready is always
// high. A write, and reset, restarts the frame: counts and positions clear
// and s_ready stays low while the cell boundaries are recomputed. The user
// must make writes only while the block is idle; the block does not check it.
module binarize_box_downsample (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bbd_pkg::PIX_W-1:0]      s_red,
    input  logic [bbd_pkg::PIX_W-1:0]      s_green,
    input  logic [bbd_pkg::PIX_W-1:0]      s_blue,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bbd_pkg::OUT_IDX_W-1:0]  m_cell_column,
    output logic [bbd_pkg::OUT_IDX_W-1:0]  m_cell_row,
    output logic [bbd_pkg::DARK_W-1:0]     m_darkness,
    output logic                           m_band_last,
    output logic                           m_image_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_UPDATE = 6'b000010,
        ST_READ   = 6'b000100,
        ST_LOAD   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    localparam int DIM_W   = bbd_pkg::DIM_W;
    localparam int GX_W    = bbd_pkg::GX_W;
    localparam int COUNT_W = bbd_pkg::COUNT_W;
    localparam int CELL_W  = bbd_pkg::CELL_W;
    localparam logic [GX_W-1:0] LAST_CELL = GX_W'(bbd_pkg::GRID - 1);

    bbd_pkg::dims_t dims;

    state_t                    state_reg;
    logic                      dark_reg;
    logic [DIM_W-1:0]          pc_reg;
    logic [GX_W-1:0]           gc_reg;
    logic [DIM_W-1:0]          pr_reg;
    logic [GX_W-1:0]           gr_reg;
    bbd_pkg::mark_t            col_hi_reg;
    bbd_pkg::mark_t            row_lo_reg;
    bbd_pkg::mark_t            row_hi_reg;
    logic [CELL_W-1:0]         rows_reg;
    logic [GX_W-1:0]           band_row_reg;
    logic                      final_reg;
    logic [GX_W-1:0]           emit_col_reg;
    bbd_pkg::mark_t            emit_lo_reg;
    bbd_pkg::mark_t            emit_hi_reg;
    logic [COUNT_W-1:0]        pixels_reg;
    logic [bbd_pkg::GRID-1:0]  cnt_valid_reg;
    logic                      rd_valid_reg;

    logic                      m_valid_reg;
    logic [GX_W-1:0]           m_col_reg;
    logic [GX_W-1:0]           m_row_reg;
    logic [bbd_pkg::DARK_W-1:0] m_dark_reg;
    logic                      m_band_last_reg;
    logic                      m_image_last_reg;

    logic [bbd_pkg::SUM_W-1:0] pix_sum;
    logic                      pix_dark;
    logic                      accept;
    logic [COUNT_W-1:0]        rd_data;
    logic [COUNT_W-1:0]        cnt_base;
    logic                      ram_rd_en;
    logic [GX_W-1:0]           ram_rd_addr;
    logic                      ram_wr_en;
    logic [DIM_W-1:0]          pc_inc;
    logic [DIM_W-1:0]          pr_inc;
    logic                      row_end;
    logic                      band_end;
    logic                      frame_end;
    logic [CELL_W-1:0]         cell_cols;
    logic                      out_free;
    logic                      div_start;
    logic                      div_done;
    logic [bbd_pkg::DARK_W-1:0] div_q;
    bbd_pkg::mark_t            zero_mark;
    bbd_pkg::mark_t            col_first;
    bbd_pkg::mark_t            row_first;

    bbd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dims      (dims)
    );

    bbd_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (bbd_pkg::GRID)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (gc_reg),
        .wr_data (cnt_base + COUNT_W'(dark_reg)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    bbd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cnt_base),
        .divisor  (pixels_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_ready  = (state_reg == ST_IDLE) && !dims.busy;
    assign accept   = s_valid && s_ready;
    assign pix_sum  = bbd_pkg::SUM_W'(s_red) + bbd_pkg::SUM_W'(s_green)
                    + bbd_pkg::SUM_W'(s_blue);
    assign pix_dark = dims.dark_ok && (pix_sum < bbd_pkg::DARK_SUM);

    // Entries not written since the last clear read as zero
    assign cnt_base    = rd_valid_reg ? rd_data : '0;
    assign ram_rd_en   = accept || (state_reg == ST_READ);
    assign ram_rd_addr = (state_reg == ST_READ) ? emit_col_reg : gc_reg;
    assign ram_wr_en   = (state_reg == ST_UPDATE);

    assign pc_inc    = pc_reg + DIM_W'(1);
    assign pr_inc    = pr_reg + DIM_W'(1);
    assign row_end   = (pc_inc == dims.width);
    assign band_end  = (pr_inc >= row_hi_reg.pos);
    assign frame_end = (pr_inc >= dims.height);
    assign cell_cols = CELL_W'(emit_hi_reg.pos - emit_lo_reg.pos);
    assign out_free  = !m_valid_reg || m_ready;
    assign div_start = (state_reg == ST_LOAD);

    assign zero_mark = '0;
    assign col_first = bbd_pkg::mark_step(zero_mark, dims.wq, dims.wr);
    assign row_first = bbd_pkg::mark_step(zero_mark, dims.hq, dims.hr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            cnt_valid_reg <= '0;
            pc_reg        <= '0;
            gc_reg        <= '0;
            pr_reg        <= '0;
            gr_reg        <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (dims.init) begin
                // Restart the frame with the new geometry
                cnt_valid_reg <= '0;
                pc_reg        <= '0;
                gc_reg        <= '0;
                pr_reg        <= '0;
                gr_reg        <= '0;
                col_hi_reg    <= col_first;
                row_lo_reg    <= zero_mark;
                row_hi_reg    <= row_first;
            end else begin
                case (state_reg)
                    ST_IDLE: begin
                        if (accept) begin
                            dark_reg     <= pix_dark;
                            rd_valid_reg <= cnt_valid_reg[gc_reg];
                            state_reg    <= ST_UPDATE;
                        end
                    end
                    ST_UPDATE: begin
                        cnt_valid_reg[gc_reg] <= 1'b1;
                        state_reg <= ST_IDLE;
                        if (!row_end) begin
                            pc_reg <= pc_inc;
                            if (pc_inc >= col_hi_reg.pos) begin
                                gc_reg     <= gc_reg + GX_W'(1);
                                col_hi_reg <= bbd_pkg::mark_step(col_hi_reg, dims.wq,
                                                                 dims.wr);
                            end
                        end else begin
                            pc_reg     <= '0;
                            gc_reg     <= '0;
                            col_hi_reg <= col_first;
                            pr_reg     <= pr_inc;
                            if (band_end) begin
                                rows_reg     <= CELL_W'(row_hi_reg.pos - row_lo_reg.pos);
                                band_row_reg <= gr_reg;
                                final_reg    <= frame_end;
                                emit_col_reg <= '0;
                                emit_lo_reg  <= zero_mark;
                                emit_hi_reg  <= col_first;
                                gr_reg       <= gr_reg + GX_W'(1);
                                row_lo_reg   <= row_hi_reg;
                                row_hi_reg   <= bbd_pkg::mark_step(row_hi_reg, dims.hq,
                                                                   dims.hr);
                                state_reg    <= ST_READ;
                            end
                            if (frame_end) begin
                                pr_reg     <= '0;
                                gr_reg     <= '0;
                                row_lo_reg <= zero_mark;
                                row_hi_reg <= row_first;
                            end
                        end
                    end
                    ST_READ: begin
                        rd_valid_reg <= cnt_valid_reg[emit_col_reg];
                        pixels_reg   <= COUNT_W'(cell_cols) * COUNT_W'(rows_reg);
                        state_reg    <= ST_LOAD;
                    end
                    ST_LOAD: begin
                        // Count is in the divider now; drop it for the next band
                        cnt_valid_reg[emit_col_reg] <= 1'b0;
                        state_reg <= ST_DIV;
                    end
                    ST_DIV: begin
                        if (div_done) begin
                            state_reg <= ST_OUT;
                        end
                    end
                    ST_OUT: begin
                        if (out_free) begin
                            m_valid_reg      <= 1'b1;
                            m_col_reg        <= emit_col_reg;
                            m_row_reg        <= band_row_reg;
                            m_dark_reg       <= div_q;
                            m_band_last_reg  <= (emit_col_reg == LAST_CELL);
                            m_image_last_reg <= (emit_col_reg == LAST_CELL) && final_reg;
                            if (emit_col_reg == LAST_CELL) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                emit_col_reg <= emit_col_reg + GX_W'(1);
                                emit_lo_reg  <= emit_hi_reg;
                                emit_hi_reg  <= bbd_pkg::mark_step(emit_hi_reg, dims.wq,
                                                                   dims.wr);
                                state_reg    <= ST_READ;
                            end
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_cell_column = bbd_pkg::OUT_IDX_W'(m_col_reg);
    assign m_cell_row    = bbd_pkg::OUT_IDX_W'(m_row_reg);
    assign m_darkness    = m_dark_reg;
    assign m_band_last   = m_band_last_reg;
    assign m_image_last  = m_image_last_reg;

`ifndef SYNTHESIS
    a_dark_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_darkness <= bbd_pkg::DARK_W'(256))
        else $error("darkness above one");

    a_image_last_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_last |-> m_band_last)
        else $error("image end without band end");

    a_update_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_UPDATE)
        else $error("accepted item not written back");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");

    a_column_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE |-> gc_reg <= LAST_CELL)
        else $error("grid column beyond grid");
`endif

endmodule
